@@ hdl/rmt_pkg.sv @@
// ----------------------------------------------------------------------------
// rmt_pkg
// Shared types and constants for the running mex tracker: field widths,
// bitmap word geometry, controller states and the first-zero search.
// ----------------------------------------------------------------------------
package rmt_pkg;

	// payload field widths
	localparam int VALUE_W = 12;
	localparam int MEX_W   = 13;

	// presence bitmap is stored as words of WORD_W flags
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BIT_W-1:0]  bit_idx_t;

	// controller states, one-hot
	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_MODIFY = 5'b00100,
		ST_SCAN   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	// lowest clear bit of a word, zero when the word is all ones
	function automatic bit_idx_t first_zero(input word_t w);
		bit_idx_t idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = bit_idx_t'(i);
			end
		end
		return idx;
	endfunction

endpackage

@@ hdl/rmt_ram.sv @@
// ----------------------------------------------------------------------------
// rmt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when a read is enabled.
// ----------------------------------------------------------------------------
module rmt_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 128,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/running_mex_tracker.sv @@
// ----------------------------------------------------------------------------
// running_mex_tracker
// Marks each incoming value in a presence bitmap and returns the smallest
// value not yet seen, saturating at VALUE_RANGE.
// ----------------------------------------------------------------------------
// The seen set lives in a RAM of 32-bit words with a registered read.
// After reset the block clears that RAM one word per cycle and holds
// in_stall high meanwhile, over all ceil(VALUE_RANGE / 32) words, 128 at
// the default. A request then passes accept and read, read-modify-write of
// the word and load of the output register; when the inserted value equals
// the current mex and its word is full, an upward scan reads further
// bitmap words before the load. Because the mex only moves upward, the
// scans over a run of requests never read the same bitmap word twice. One
// request is in flight at a time; the output register lets the next
// request in while a result waits. Values at or above VALUE_RANGE are
// ignored and return the current mex, since the bitmap is neither read
// nor written for them.
module running_mex_tracker
	import rmt_pkg::*;
#(
	parameter int VALUE_RANGE = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [MEX_W-1:0]   mex
);

	localparam int NWORDS  = (VALUE_RANGE + WORD_W - 1) / WORD_W;
	localparam int ADDR_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int CMEX_W  = $clog2(VALUE_RANGE + 1);
	localparam int LIM_W   = ADDR_W + BIT_W + 1;

	typedef logic [ADDR_W-1:0] addr_t;

	state_t               state_q;
	addr_t                clr_idx_q;
	addr_t                scan_idx_q;
	logic [VALUE_W-1:0]   value_q;
	logic [CMEX_W-1:0]    cur_mex_q;
	logic                 out_valid_q;
	logic [MEX_W-1:0]     out_mex_q;

	logic                 accept;
	logic                 in_range;
	logic [31:0]          in_word;
	logic [31:0]          held_word;
	addr_t                in_addr;
	addr_t                held_addr;
	logic                 hits_mex;
	word_t                mod_word;

	logic                 ram_we;
	addr_t                ram_waddr;
	word_t                ram_wdata;
	logic                 ram_re;
	addr_t                ram_raddr;
	word_t                ram_rdata;

	word_t                scan_word;
	addr_t                scan_base;
	logic                 scan_full;
	logic                 scan_more;
	bit_idx_t             scan_zero;
	logic [LIM_W-1:0]     scan_cand;
	logic [CMEX_W-1:0]    scan_mex;
	logic                 out_free;

	// request handshake
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_range = (32'(value) < 32'(VALUE_RANGE));

	// bitmap word addresses of the incoming and the held value
	assign in_word   = 32'(value) >> BIT_W;
	assign held_word = 32'(value_q) >> BIT_W;
	assign in_addr   = in_word[ADDR_W-1:0];
	assign held_addr = held_word[ADDR_W-1:0];
	assign hits_mex  = (32'(value_q) == 32'(cur_mex_q));
	assign mod_word  = ram_rdata | (word_t'(1) << value_q[BIT_W-1:0]);

	// upward scan: first clear flag in the word at hand, clamped to the range
	assign scan_word = (state_q == ST_SCAN) ? ram_rdata : mod_word;
	assign scan_base = (state_q == ST_SCAN) ? scan_idx_q : held_addr;
	assign scan_full = &scan_word;
	assign scan_more = ((32'(scan_base) + 32'd1) < 32'(NWORDS));
	assign scan_zero = first_zero(scan_word);
	always_comb begin
		scan_cand = {1'b0, scan_base, scan_zero};
		if (scan_full || (scan_cand >= LIM_W'(VALUE_RANGE))) begin
			scan_mex = CMEX_W'(VALUE_RANGE);
		end else begin
			scan_mex = scan_cand[CMEX_W-1:0];
		end
	end

	// ram port control: clearing pass, write-back, reads
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = held_addr;
		ram_wdata = mod_word;
		ram_re    = 1'b0;
		ram_raddr = in_addr;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_re = accept && in_range;
			end
			ST_MODIFY: begin
				ram_we    = 1'b1;
				ram_re    = hits_mex && scan_full && scan_more;
				ram_raddr = scan_base + addr_t'(1);
			end
			ST_SCAN: begin
				ram_re    = scan_full && scan_more;
				ram_raddr = scan_base + addr_t'(1);
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	rmt_ram #(
		.WIDTH  (WORD_W),
		.DEPTH  (NWORDS),
		.ADDR_W (ADDR_W)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free = !out_valid_q || !out_stall;

	// controller and current mex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			cur_mex_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + addr_t'(1);
					if (32'(clr_idx_q) == 32'(NWORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= in_range ? ST_MODIFY : ST_DONE;
					end
				end
				ST_MODIFY: begin
					if (hits_mex && scan_full && scan_more) begin
						state_q <= ST_SCAN;
					end else begin
						if (hits_mex) begin
							cur_mex_q <= scan_mex;
						end
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (!(scan_full && scan_more)) begin
						cur_mex_q <= scan_mex;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// result valid: set on load, cleared once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// held request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value;
		end
		if ((state_q == ST_MODIFY) || (state_q == ST_SCAN)) begin
			scan_idx_q <= scan_base + addr_t'(1);
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_mex_q <= MEX_W'(32'(cur_mex_q));
		end
	end

	assign out_valid = out_valid_q;
	assign mex       = out_mex_q;

	// no request is taken while the bitmap is being cleared
	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> in_stall)
		else $error("request accepted during clearing pass");

	// the mex never moves downward
	a_mex_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (cur_mex_q >= $past(cur_mex_q)))
		else $error("current mex decreased");

	// the mex saturates at the value range
	a_mex_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_mex_q) <= 32'(VALUE_RANGE))
		else $error("current mex beyond value range");

	// the scan only reads, the bitmap is written during clear and write-back
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) || (state_q == ST_IDLE) || (state_q == ST_DONE))
		|-> !ram_we)
		else $error("bitmap written outside clear or write-back");

endmodule

@@ dv/rmt_mex_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rmt_mex_checker
// Watches both channels of the running mex tracker. Every accepted request
// updates a private seen set and mex register, and the expected mex is
// queued. Every accepted result is compared with the oldest queued mex.
// ----------------------------------------------------------------------------
module rmt_mex_checker
	import rmt_pkg::*;
#(
	parameter int VALUE_RANGE = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [VALUE_W-1:0] value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [MEX_W-1:0]   mex,
	output int                 fail_count,
	output int                 pending,
	output int                 req_count,
	output int                 res_count,
	output logic [MEX_W-1:0]   mex_tracked
);

	// private copy of the block state
	bit               seen_flags [VALUE_RANGE];
	logic [MEX_W-1:0] mex_now;
	logic [MEX_W-1:0] mex_due [$];

	initial begin
		fail_count = 0;
		pending    = 0;
		req_count  = 0;
		res_count  = 0;
	end

	// print one line per mismatch and count it
	task automatic report(input string msg);
		$display("[%0t] error: %s", $realtime, msg);
		fail_count++;
	endtask

	// mark the value present and move the mex up past present values
	function automatic logic [MEX_W-1:0] insert_and_get_mex(input logic [VALUE_W-1:0] v);
		int m;
		if (int'(v) < VALUE_RANGE) begin
			seen_flags[v] = 1'b1;
			if (MEX_W'(v) == mex_now) begin
				m = int'(mex_now);
				while (m < VALUE_RANGE && seen_flags[m]) begin
					m++;
				end
				mex_now = MEX_W'(m);
			end
		end
		return mex_now;
	endfunction

	// sample both channels at the rising edge
	always @(posedge clk) begin
		logic [MEX_W-1:0] want;
		if (!arst_n) begin
			foreach (seen_flags[i]) seen_flags[i] = 1'b0;
			mex_now = '0;
			mex_due.delete();
		end else begin
			// results first, so a result never pairs with a request of the same edge
			if (out_valid && !out_stall) begin
				res_count++;
				if (mex_due.size() == 0) begin
					report($sformatf("result mex=%0d with no request outstanding", mex));
				end else begin
					want = mex_due.pop_front();
					if (mex !== want) begin
						report($sformatf("result %0d: mex=%0d, predicted %0d",
							res_count, mex, want));
					end
				end
			end
			if (in_valid && !in_stall) begin
				req_count++;
				want = insert_and_get_mex(value);
				mex_due.insert(mex_due.size(), want);
			end
		end
		pending     = mex_due.size();
		mex_tracked = mex_now;
	end

endmodule

@@ dv/tb_running_mex_tracker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_mex_tracker
// Stimulus and verdict for the running mex tracker. A short directed list
// hits repeats, the value extremes and a held-back value that releases a
// scan; random requests then walk mostly along the current mex with some
// values placed ahead of it, and eight random values close the run.
// Both channels idle at random; a checker does the scoring.
// ----------------------------------------------------------------------------
module tb_running_mex_tracker
	import rmt_pkg::*;
();

	localparam int RANGE       = 4096;
	localparam int RAND_REQS   = 468;
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 20;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [VALUE_W-1:0] value;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [MEX_W-1:0]   mex;

	int               fail_count;
	int               pending;
	int               req_count;
	int               res_count;
	logic [MEX_W-1:0] mex_tracked;

	// stimulus bookkeeping: values already sent and the lowest one not sent
	bit sent_flags [RANGE];
	int next_unsent = 0;
	int calm_left   = 0;
	int idle_cycles = 0;

	running_mex_tracker #(
		.VALUE_RANGE(RANGE)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mex      (mex)
	);

	rmt_mex_checker #(
		.VALUE_RANGE(RANGE)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.mex        (mex),
		.fail_count (fail_count),
		.pending    (pending),
		.req_count  (req_count),
		.res_count  (res_count),
		.mex_tracked(mex_tracked)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side stall: short bursts, a few long ones, long stall-free runs
	int stall_left = 0;
	int free_left  = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (free_left > 0) begin
			free_left--;
			out_stall <= 1'b0;
		end else begin
			stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 48) :
				$urandom_range(0, 2);
			free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) :
				$urandom_range(0, 5);
			out_stall <= (stall_left > 0);
			if (stall_left > 0) stall_left--;
		end
	end

	// watchdog: cycles in a row with no handshake on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d cycles without a handshake", IDLE_LIMIT);
			$display("running_mex_tracker: mismatch");
			$finish;
		end
	end

	// idle cycles before a request: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// drive one request and hold it until accepted
	task automatic send_value(input int v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		value    = VALUE_W'(v);
		do @(posedge clk); while (in_stall);
		sent_flags[v] = 1'b1;
		while (next_unsent < RANGE && sent_flags[next_unsent]) next_unsent++;
	endtask

	// hold off the sender until every result is back
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	// random value, mostly at or just past the lowest unsent value
	function automatic int pick_value();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (next_unsent >= RANGE || r >= 88) return $urandom_range(0, RANGE - 1);
		if (r < 45) return next_unsent;
		if (r < 72) begin
			v = next_unsent + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 100) :
				$urandom_range(1, 8));
			return (v > RANGE - 1) ? RANGE - 1 : v;
		end
		return (next_unsent > 0) ? $urandom_range(0, next_unsent - 1) : 0;
	endfunction

	int directed [] = '{0, 0, 4095, 2, 1, 3, 4, 2048, 2047, 4094, 1365, 2730,
		6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 5, 4095};

	initial begin
		in_valid = 1'b0;
		value    = '0;
		arst_n   = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: repeats, extremes, a held-back value releasing a scan
		foreach (directed[i]) send_value(directed[i]);
		wait_drained();

		// random walk along the mex with periodic full drains
		for (int n = 0; n < RAND_REQS; n++) begin
			send_value(pick_value());
			if (n % 128 == 127) wait_drained();
		end
		wait_drained();

		// eight random values
		repeat (8) send_value($urandom_range(0, RANGE - 1));

		// drain and let the block settle
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests and %0d results with random stalls on both sides",
			req_count, res_count);
		$display("final mex %0d of range %0d, %0d mismatches", mex_tracked, RANGE,
			fail_count);
		if (fail_count == 0) begin
			$display("running_mex_tracker: match");
		end else begin
			$display("running_mex_tracker: mismatch");
		end
		$finish;
	end

endmodule
